FILE: sv/srlc_pkg.sv
// Shared types and constants of the segment register load/check block.
// No dependencies; the design modules import this package.
package srlc_pkg;

  localparam int unsigned NUM_SEG = 6;

  // Segment register numbers
  localparam logic [2:0] SEG_ES = 3'd0;
  localparam logic [2:0] SEG_CS = 3'd1;
  localparam logic [2:0] SEG_SS = 3'd2;
  localparam logic [2:0] SEG_DS = 3'd3;
  localparam logic [2:0] SEG_FS = 3'd4;
  localparam logic [2:0] SEG_GS = 3'd5;
  localparam logic [2:0] SEG_LAST = SEG_GS;

  // Item functions
  localparam logic FUNC_LOAD     = 1'b0;
  localparam logic FUNC_VALIDATE = 1'b1;

  // CPU modes
  localparam logic [1:0] MODE_REAL = 2'd0;
  localparam logic [1:0] MODE_V86  = 2'd1;
  localparam logic [1:0] MODE_PROT = 2'd2;
  localparam logic [1:0] MODE_LONG = 2'd3;

  // Fault codes
  localparam logic [2:0] FAULT_NONE   = 3'd0;
  localparam logic [2:0] FAULT_GP     = 3'd1;
  localparam logic [2:0] FAULT_SS     = 3'd2;
  localparam logic [2:0] FAULT_NP     = 3'd3;
  localparam logic [2:0] FAULT_NOLOAD = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] CFG_GDT_BASE  = 3'd0;
  localparam logic [2:0] CFG_GDT_LIMIT = 3'd1;
  localparam logic [2:0] CFG_LDT_BASE  = 3'd2;
  localparam logic [2:0] CFG_LDT_LIMIT = 3'd3;
  localparam logic [2:0] CFG_LDT_VALID = 3'd4;

  localparam logic [15:0] SEL_ERR_MASK   = 16'hfffc;
  localparam logic [31:0] ACCESSED_BIT   = 32'h0000_0100;
  localparam logic [31:0] RESET_LIMIT    = 32'h0000_ffff;
  localparam logic [11:0] GRAN_FILL      = 12'hfff;
  localparam logic [15:0] REAL_ATTR_KEEP = 16'hff60;  // keep DPL and upper attributes
  localparam logic [15:0] REAL_ATTR_SET  = 16'h0090;  // S and P
  localparam logic [15:0] V86_ATTR_SET   = 16'h00f0;  // S, DPL 3, P
  localparam logic [3:0]  TYPE_CODE_RX   = 4'hb;
  localparam logic [3:0]  TYPE_DATA_RW   = 4'h3;

  typedef struct packed {
    logic [31:0] gdt_base;
    logic [15:0] gdt_limit;
    logic [31:0] ldt_base;
    logic [31:0] ldt_limit;
    logic        ldt_valid;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] selector;
    logic [31:0] base;
    logic [31:0] limit;
    logic [15:0] attr;
  } seg_entry_t;

  typedef struct packed {
    logic        func;
    logic [2:0]  seg_index;
    logic [15:0] selector_value;
    logic [31:0] desc_low;
    logic [31:0] desc_high;
    logic [1:0]  cpl;
    logic [1:0]  exec_mode;
  } item_t;

  typedef struct packed {
    logic [2:0]  fault;
    logic [15:0] error_code;
    logic        write_back;
    logic [31:0] write_address;
    logic [31:0] write_word;
    seg_entry_t  seg;
  } result_t;

  typedef struct packed {
    logic       en;
    logic [2:0] idx;
    seg_entry_t entry;
  } seg_wr_t;

endpackage

FILE: sv/srlc_in_if.sv
// Input channel: valid/ready handshake with one load or validate item per beat.
// No dependencies.
interface srlc_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [2:0]  seg_index;
  logic [15:0] selector_value;
  logic [31:0] desc_low;
  logic [31:0] desc_high;
  logic [1:0]  cpl;
  logic [1:0]  exec_mode;

  modport source (output valid, func, seg_index, selector_value, desc_low, desc_high,
                  cpl, exec_mode, input ready);
  modport sink (input valid, func, seg_index, selector_value, desc_low, desc_high,
                cpl, exec_mode, output ready);
endinterface

FILE: sv/srlc_out_if.sv
// Result channel: valid/ready handshake with one result per beat.
// No dependencies.
interface srlc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  fault;
  logic [15:0] error_code;
  logic        write_back;
  logic [31:0] write_address;
  logic [31:0] write_word;
  logic        seg_valid;
  logic [15:0] seg_selector;
  logic [31:0] seg_base;
  logic [31:0] seg_limit;
  logic [15:0] seg_attr;

  modport source (output valid, fault, error_code, write_back, write_address, write_word,
                  seg_valid, seg_selector, seg_base, seg_limit, seg_attr, input ready);
  modport sink (input valid, fault, error_code, write_back, write_address, write_word,
                seg_valid, seg_selector, seg_base, seg_limit, seg_attr, output ready);
endinterface

FILE: sv/srlc_cfg_if.sv
// Configuration write channel: register index and data per beat.
// No dependencies.
interface srlc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/segment_register_load_check.sv
// Segment register file with protected-mode load checks.
// Depends on srlc_pkg, the three channel interfaces, srlc_cfg_regs, srlc_seg_file, srlc_check.
//
// Channels: in_if carries load or validate items, out_if one result per item,
// cfg_if writes the descriptor table registers (index 0..4, always ready; write
// only while no item is in flight). All channels beat on valid && ready.
// An accepted item lands in the input register, is checked and decoded there
// against the addressed segment entry, and its result is captured in
// the output register while the entry is updated at the same edge.
// Throughput: one item per cycle while the receiver takes results; the single check
// stage reads the entry that the previous item wrote, so back-to-back items to one register chain cleanly.
// Reset: all control state clears; entries come up with zero selector, base,
// attributes and valid, limit 0xffff; GDT limit resets to 0xffff, the rest to 0.
// Receiver stall: the output register holds its result; one more item waits in
// the input register, then in_if.ready drops until out_if.ready returns.
module segment_register_load_check (
  input  logic        clk,
  input  logic        rst_n,
  srlc_in_if.sink     in_if,
  srlc_out_if.source  out_if,
  srlc_cfg_if.sink    cfg_if
);
  import srlc_pkg::*;

  cfg_t       cfg;
  item_t      item_r;
  item_t      item_nxt;
  logic       in_valid_r;
  logic       in_valid_nxt;
  result_t    res_r;
  result_t    res_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       adv;
  logic       fire;
  seg_entry_t rd_entry;
  result_t    chk_res;
  seg_wr_t    chk_wr;
  seg_wr_t    seg_wr;

  srlc_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  srlc_seg_file u_seg (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (item_r.seg_index),
    .rd_entry (rd_entry),
    .wr       (seg_wr)
  );

  srlc_check u_chk (
    .item   (item_r),
    .entry  (rd_entry),
    .cfg    (cfg),
    .result (chk_res),
    .wr     (chk_wr)
  );

  assign adv         = !out_valid_r || out_if.ready;
  assign fire        = in_valid_r && adv;
  assign in_if.ready = !in_valid_r || adv;

  always_comb begin
    seg_wr    = chk_wr;
    seg_wr.en = chk_wr.en && fire;
  end

  always_comb begin
    item_nxt      = item_r;
    in_valid_nxt  = in_valid_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    // take a new beat whenever the input register frees up
    if (in_if.ready) begin
      in_valid_nxt            = in_if.valid;
      item_nxt.func           = in_if.func;
      item_nxt.seg_index      = in_if.seg_index;
      item_nxt.selector_value = in_if.selector_value;
      item_nxt.desc_low       = in_if.desc_low;
      item_nxt.desc_high      = in_if.desc_high;
      item_nxt.cpl            = in_if.cpl;
      item_nxt.exec_mode      = in_if.exec_mode;
    end
    if (adv) begin
      out_valid_nxt = in_valid_r;
      if (in_valid_r) begin
        res_nxt = chk_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.fault         = res_r.fault;
  assign out_if.error_code    = res_r.error_code;
  assign out_if.write_back    = res_r.write_back;
  assign out_if.write_address = res_r.write_address;
  assign out_if.write_word    = res_r.write_word;
  assign out_if.seg_valid     = res_r.seg.valid;
  assign out_if.seg_selector  = res_r.seg.selector;
  assign out_if.seg_base      = res_r.seg.base;
  assign out_if.seg_limit     = res_r.seg.limit;
  assign out_if.seg_attr      = res_r.seg.attr;

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("processed item did not produce a result");

  a_full_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && out_valid_r && !out_if.ready) |-> !in_if.ready)
    else $error("input accepted while both stages are full and stalled");

  a_fault_no_writeback: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.fault != FAULT_NONE && res_r.write_back))
    else $error("write-back requested on a faulting load");

  a_writeback_accessed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.write_back) |-> res_r.write_word[8])
    else $error("write-back word lacks the accessed bit");

  a_err_rpl_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.error_code[1:0] == 2'b00))
    else $error("error code carries RPL bits");

endmodule

FILE: sv/srlc_cfg_regs.sv
// Descriptor table configuration registers, written over the cfg channel.
// Depends on srlc_pkg and srlc_cfg_if.
module srlc_cfg_regs (
  input  logic             clk,
  input  logic             rst_n,
  srlc_cfg_if.sink         cfg_if,
  output srlc_pkg::cfg_t   cfg
);
  import srlc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_if.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_GDT_BASE:  cfg_nxt.gdt_base  = cfg_if.data;
        CFG_GDT_LIMIT: cfg_nxt.gdt_limit = cfg_if.data[15:0];
        CFG_LDT_BASE:  cfg_nxt.ldt_base  = cfg_if.data;
        CFG_LDT_LIMIT: cfg_nxt.ldt_limit = cfg_if.data;
        CFG_LDT_VALID: cfg_nxt.ldt_valid = cfg_if.data[0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gdt_base  <= '0;
      cfg_r.gdt_limit <= 16'hffff;
      cfg_r.ldt_base  <= '0;
      cfg_r.ldt_limit <= '0;
      cfg_r.ldt_valid <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: sv/srlc_seg_file.sv
// Six-entry segment register file: one combinational read, one write per cycle.
// Depends on srlc_pkg.
module srlc_seg_file (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [2:0]           rd_idx,
  output srlc_pkg::seg_entry_t rd_entry,
  input  srlc_pkg::seg_wr_t    wr
);
  import srlc_pkg::*;

  seg_entry_t ent_r [NUM_SEG];

  // Out-of-range register numbers read as all zero.
  assign rd_entry = (rd_idx <= SEG_LAST) ? ent_r[rd_idx] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SEG; i++) begin
        ent_r[i] <= '{valid: 1'b0, selector: '0, base: '0, limit: RESET_LIMIT, attr: '0};
      end
    end else if (wr.en && wr.idx <= SEG_LAST) begin
      ent_r[wr.idx] <= wr.entry;
    end
  end

endmodule

FILE: sv/srlc_check.sv
// Load/validate check and descriptor decode for one item against one register entry.
// Depends on srlc_pkg.
module srlc_check (
  input  srlc_pkg::item_t      item,
  input  srlc_pkg::seg_entry_t entry,
  input  srlc_pkg::cfg_t       cfg,
  output srlc_pkg::result_t    result,
  output srlc_pkg::seg_wr_t    wr
);
  import srlc_pkg::*;

  logic [15:0] sel;
  logic [31:0] lo;
  logic [31:0] hi;
  logic [15:0] err;
  logic [1:0]  rpl;
  logic [15:0] idx8;
  logic [15:0] idx_end;
  logic        tbl_local;
  logic [31:0] tbase;
  logic        tbl_fault;
  logic [3:0]  dtype;
  logic        dsc_s;
  logic [1:0]  dpl;
  logic        dsc_p;
  logic        is_code;
  logic [2:0]  fault;
  logic [19:0] lim20;
  logic [31:0] lim;
  logic [31:0] dbase;
  logic [3:0]  rm_type;
  logic [1:0]  edpl;
  seg_entry_t  ent;

  assign sel       = item.selector_value;
  assign lo        = item.desc_low;
  assign hi        = item.desc_high;
  assign err       = sel & SEL_ERR_MASK;
  assign rpl       = sel[1:0];
  assign idx8      = {sel[15:3], 3'b000};
  assign idx_end   = idx8 + 16'd7;
  assign tbl_local = sel[2];
  assign tbase     = tbl_local ? cfg.ldt_base : cfg.gdt_base;
  assign tbl_fault = tbl_local ? (!cfg.ldt_valid || {16'h0, idx_end} > cfg.ldt_limit)
                               : (idx_end > cfg.gdt_limit);
  assign dtype     = hi[11:8];
  assign dsc_s     = hi[12];
  assign dpl       = hi[14:13];
  assign dsc_p     = hi[15];
  assign is_code   = dtype[3];
  assign lim20     = {hi[19:16], lo[15:0]};
  assign lim       = hi[23] ? {lim20, GRAN_FILL} : {12'h000, lim20};
  assign dbase     = {hi[31:24], hi[7:0], lo[31:16]};
  assign rm_type   = (item.seg_index == SEG_CS) ? TYPE_CODE_RX : TYPE_DATA_RW;
  assign edpl      = entry.attr[6:5];

  // Descriptor rule checks, in priority order.
  always_comb begin
    fault = FAULT_NONE;
    if (tbl_fault) begin
      fault = FAULT_GP;
    end else if (item.seg_index == SEG_SS) begin
      if (rpl != item.cpl)                          fault = FAULT_GP;
      else if (!dsc_s || is_code || !dtype[1])      fault = FAULT_GP;
      else if (dpl != item.cpl)                     fault = FAULT_GP;
      else if (!dsc_p)                              fault = FAULT_SS;
    end else begin
      if (!dsc_s || (is_code && !dtype[1]))         fault = FAULT_GP;
      else if ((!is_code || !dtype[2]) && (rpl > dpl || item.cpl > dpl))
                                                    fault = FAULT_GP;
      else if (!dsc_p)                              fault = FAULT_NP;
    end
  end

  always_comb begin
    ent    = entry;
    result = '0;
    wr     = '0;
    if (item.seg_index > SEG_LAST) begin
      result.fault = FAULT_NOLOAD;
    end else if (item.func == FUNC_VALIDATE) begin
      // Null a data register the new privilege can no longer reach,
      // unless it holds a valid conforming code segment.
      if (item.seg_index != SEG_CS && item.seg_index != SEG_SS && edpl < item.cpl &&
          (!entry.valid || !entry.attr[4] || !entry.attr[3] || !entry.attr[2])) begin
        ent.selector = '0;
        ent.valid    = 1'b0;
        wr.en        = 1'b1;
      end
    end else if (item.exec_mode == MODE_REAL || item.exec_mode == MODE_V86) begin
      ent.selector = sel;
      ent.valid    = 1'b1;
      ent.base     = {12'h000, sel, 4'h0};
      if (item.exec_mode == MODE_REAL) begin
        ent.attr = (entry.attr & REAL_ATTR_KEEP) | {12'h000, rm_type} | REAL_ATTR_SET;
      end else begin
        ent.attr  = {12'h000, rm_type} | V86_ATTR_SET;
        ent.limit = RESET_LIMIT;
      end
      wr.en = 1'b1;
    end else if (item.seg_index == SEG_CS) begin
      result.fault = FAULT_NOLOAD;
    end else if (err == 16'h0000) begin
      if (item.seg_index != SEG_SS ||
          (item.exec_mode == MODE_LONG && item.cpl != 2'd3 && rpl == item.cpl)) begin
        ent.selector = '0;
        ent.valid    = 1'b0;
        wr.en        = 1'b1;
      end else begin
        result.fault = FAULT_GP;
      end
    end else if (fault != FAULT_NONE) begin
      result.fault      = fault;
      result.error_code = err;
    end else begin
      ent.selector = sel;
      ent.base     = dbase;
      ent.limit    = lim;
      ent.attr     = {hi[23:20], 4'h0, hi[15:8]};
      ent.valid    = 1'b1;
      wr.en        = 1'b1;
      if (item.seg_index == SEG_SS || !hi[8]) begin
        result.write_back    = 1'b1;
        result.write_address = tbase + {16'h0000, idx8} + 32'd4;
        result.write_word    = hi | ACCESSED_BIT;
      end
    end
    if (item.seg_index <= SEG_LAST) begin
      result.seg = ent;
    end
    wr.idx   = item.seg_index;
    wr.entry = ent;
  end

endmodule
